### sv/fsp_pkg.sv
package fsp_pkg;

    // Command codes carried in the input tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BALL  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_FPS      = 3'd0,
        REG_INTERVAL = 3'd1,
        REG_MAX_SKIP = 3'd2,
        REG_AUTO     = 3'd3,
        REG_REFRESH  = 3'd4
    } reg_idx_t;

    localparam int ADDR_W = 5;

    localparam logic [7:0] FPS_RESET      = 8'd60;
    localparam logic [9:0] INTERVAL_RESET = 10'd16;
    localparam logic [6:0] MAX_SKIP_RESET = 7'd2;
    localparam logic       AUTO_RESET     = 1'b1;
    localparam logic [9:0] REFRESH_RESET  = 10'd0;

    localparam int MS_PER_SEC = 1000;
    localparam logic [6:0] HOLD_LIMIT = 7'd80;

    // x / 1000 == (x * RECIP_32) >> 41, exact for any 32-bit x
    localparam logic [31:0] RECIP_32 = 32'd2199023256;
    localparam int          RECIP_32_SHIFT = 41;
    // x / 1000 == (x * RECIP_18) >> 28, exact for any 18-bit x
    localparam logic [18:0] RECIP_18 = 19'd268436;
    localparam int          RECIP_18_SHIFT = 28;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now_ms;
        logic [31:0] key_states;
        logic [31:0] ball_key_a;
        logic [7:0]  ball_time_a;
        logic [31:0] ball_key_b;
        logic [7:0]  ball_time_b;
    } item_t;

endpackage

### sv/frame_skip_pacer.sv
// frame_skip_pacer
// Path: an accepted frame tick runs through the six-stage divide-by-1000 pipeline and the single
// decision stage that owns all pacing state, then its result beat is registered onto m_tvalid.
// Throughput: one beat per cycle while m_tready does not stall the output register.
// Reset: aresetn is synchronous, active low; clears all pacing state, the pipeline and
// puts the registers back to their power-on values (60 fps, 16 ms, 2 skips, auto on).
module frame_skip_pacer (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // now_ms[31:0], key_states[63:32], ball_key_a[95:64], ball_time_a[103:96],
    // ball_key_b[135:104], ball_time_b[143:136]
    input  logic [143:0]              s_tdata,
    // cmd[1:0]
    input  logic [1:0]                s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // merged_keys[31:0], wait_ms[41:32], zero pad[47:42]
    output logic [47:0]               m_tdata,
    // skip_render[0]
    output logic                      m_tuser,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fsp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] fps_reg;
    logic [9:0] interval_reg;
    logic [6:0] max_skip_reg;
    logic       auto_reg;
    logic [9:0] refresh_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fps_reg      <= fsp_pkg::FPS_RESET;
            interval_reg <= fsp_pkg::INTERVAL_RESET;
            max_skip_reg <= fsp_pkg::MAX_SKIP_RESET;
            auto_reg     <= fsp_pkg::AUTO_RESET;
            refresh_reg  <= fsp_pkg::REFRESH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                fsp_pkg::REG_FPS:      fps_reg      <= pwdata[7:0];
                fsp_pkg::REG_INTERVAL: interval_reg <= pwdata[9:0];
                fsp_pkg::REG_MAX_SKIP: max_skip_reg <= pwdata[6:0];
                fsp_pkg::REG_AUTO:     auto_reg     <= pwdata[0];
                fsp_pkg::REG_REFRESH:  refresh_reg  <= pwdata[9:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fsp_pkg::REG_FPS:      prdata = {24'd0, fps_reg};
            fsp_pkg::REG_INTERVAL: prdata = {22'd0, interval_reg};
            fsp_pkg::REG_MAX_SKIP: prdata = {25'd0, max_skip_reg};
            fsp_pkg::REG_AUTO:     prdata = {31'd0, auto_reg};
            fsp_pkg::REG_REFRESH:  prdata = {22'd0, refresh_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when empty or when the one
    // after it moves, so bubbles collapse and input keeps flowing into empty
    // stages while a result beat sits in the output register.
    // ------------------------------------------------------------------
    logic [NSTG:1]  vld_reg;
    logic [NSTG:1]  ld;
    logic           ld_out;
    logic           fire;
    fsp_pkg::item_t s_item;
    fsp_pkg::item_t itm_reg [1:NSTG];

    logic           m_valid_reg;

    always_comb begin
        ld_out   = !m_valid_reg || m_tready;
        ld[NSTG] = !vld_reg[NSTG] || ld_out;
        for (int k = NSTG - 1; k >= 1; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign s_tready = ld[1];
    assign fire     = vld_reg[NSTG] && ld_out;

    assign s_item.cmd         = fsp_pkg::cmd_t'(s_tuser);
    assign s_item.now_ms      = s_tdata[31:0];
    assign s_item.key_states  = s_tdata[63:32];
    assign s_item.ball_key_a  = s_tdata[95:64];
    assign s_item.ball_time_a = s_tdata[103:96];
    assign s_item.ball_key_b  = s_tdata[135:104];
    assign s_item.ball_time_b = s_tdata[143:136];

    // Front copy of the run start time. Only a start beat changes it and
    // beats stay in order, so subtracting at entry sees the same value the
    // decision stage would.
    logic [31:0] start_front_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_front_reg <= 32'd0;
        end else if (s_tvalid && s_tready && s_item.cmd == fsp_pkg::CMD_START) begin
            start_front_reg <= s_item.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            itm_reg[1] <= s_item;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (ld[k]) begin
                itm_reg[k] <= itm_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // real frames = elapsed * fps / 1000, split as
    // elapsed = 1000*q + b  ->  real = q*fps + (b*fps)/1000
    // ------------------------------------------------------------------
    logic [31:0] el1_reg, el2_reg;
    logic [22:0] q2_reg, q3_reg;
    logic [9:0]  b3_reg;
    logic [30:0] m1_4_reg, m1_5_reg;
    logic [17:0] m2_4_reg;
    logic [8:0]  r5_reg;
    logic [30:0] real6_reg;

    logic [63:0] q_prod;
    logic [32:0] q_x1000;
    logic [31:0] rem;
    logic [36:0] r_prod;

    assign q_prod  = 64'(el1_reg) * 64'(fsp_pkg::RECIP_32);
    assign q_x1000 = 33'(q2_reg) * 33'(fsp_pkg::MS_PER_SEC);
    assign rem     = el2_reg - q_x1000[31:0];
    assign r_prod  = 37'(m2_4_reg) * 37'(fsp_pkg::RECIP_18);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            el1_reg <= s_item.now_ms - start_front_reg;
        end
        if (ld[2]) begin
            el2_reg <= el1_reg;
            q2_reg  <= q_prod[63:fsp_pkg::RECIP_32_SHIFT];
        end
        if (ld[3]) begin
            q3_reg <= q2_reg;
            b3_reg <= rem[9:0];
        end
        if (ld[4]) begin
            m1_4_reg <= 31'(q3_reg) * 31'(fps_reg);
            m2_4_reg <= 18'(b3_reg) * 18'(fps_reg);
        end
        if (ld[5]) begin
            m1_5_reg <= m1_4_reg;
            r5_reg   <= r_prod[36:fsp_pkg::RECIP_18_SHIFT];
        end
        if (ld[6]) begin
            real6_reg <= m1_5_reg + 31'(r5_reg);
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: owns all pacing and trackball state
    // ------------------------------------------------------------------
    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] last_drawn_reg, last_drawn_next;
    logic [31:0] vframes_reg, vframes_next;
    logic [6:0]  skip_cnt_reg, skip_cnt_next;
    logic [31:0] held_key_reg [2];
    logic [31:0] held_key_next [2];
    logic [6:0]  hold_left_reg [2];
    logic [6:0]  hold_left_next [2];

    logic        tick_out;
    logic        skip_out;
    logic [31:0] keys_out;
    logic [9:0]  wait_out;

    fsp_pkg::item_t cur;
    assign cur = itm_reg[NSTG];

    always_comb begin
        logic [31:0] real32;
        logic [31:0] vf1;
        logic [31:0] delta;
        logic [31:0] ball_key [2];
        logic [7:0]  ball_time [2];
        logic [8:0]  hsum;
        logic [6:0]  hbase;
        logic [7:0]  cnt_inc;

        last_time_next  = last_time_reg;
        last_drawn_next = last_drawn_reg;
        vframes_next    = vframes_reg;
        skip_cnt_next   = skip_cnt_reg;
        held_key_next   = held_key_reg;
        hold_left_next  = hold_left_reg;
        tick_out        = 1'b0;
        skip_out        = 1'b0;
        keys_out        = cur.key_states;
        wait_out        = 10'd0;

        real32       = {1'b0, real6_reg};
        vf1          = vframes_reg + 32'd1;
        delta        = cur.now_ms - last_time_reg;
        ball_key[0]  = cur.ball_key_a;
        ball_key[1]  = cur.ball_key_b;
        ball_time[0] = cur.ball_time_a;
        ball_time[1] = cur.ball_time_b;
        hsum         = 9'd0;
        hbase        = 7'd0;
        cnt_inc      = 8'd0;

        unique case (cur.cmd)
            fsp_pkg::CMD_START: begin
                last_time_next  = cur.now_ms;
                last_drawn_next = 32'd0;
                vframes_next    = 32'd0;
                skip_cnt_next   = 7'd0;
            end
            fsp_pkg::CMD_BALL: begin
                for (int i = 0; i < 2; i++) begin
                    if (ball_key[i] != 32'd0) begin
                        // a different key restarts the hold time
                        hbase = (held_key_reg[i] != ball_key[i]) ? 7'd0 : hold_left_reg[i];
                        hsum  = 9'(hbase) + 9'(ball_time[i]);
                        held_key_next[i]  = ball_key[i];
                        hold_left_next[i] = (hsum > 9'(fsp_pkg::HOLD_LIMIT)) ?
                                            fsp_pkg::HOLD_LIMIT : hsum[6:0];
                    end
                end
            end
            fsp_pkg::CMD_TICK: begin
                tick_out     = 1'b1;
                vframes_next = vf1;
                if (real32 >= vf1) begin
                    // behind real time
                    if (real32 > vf1 && auto_reg && skip_cnt_reg < max_skip_reg) begin
                        skip_cnt_next = skip_cnt_reg + 7'd1;
                    end else begin
                        vframes_next = real32;
                        if (auto_reg) begin
                            skip_cnt_next = 7'd0;
                        end
                    end
                end else if (delta < 32'(interval_reg)) begin
                    // ahead: wait out the rest of the frame interval
                    wait_out = interval_reg - delta[9:0];
                end
                if (!auto_reg) begin
                    cnt_inc       = 8'(skip_cnt_next) + 8'd1;
                    skip_cnt_next = (cnt_inc > 8'(max_skip_reg)) ? 7'd0 : cnt_inc[6:0];
                end
                last_time_next = cur.now_ms;

                for (int i = 0; i < 2; i++) begin
                    if (hold_left_reg[i] != 7'd0) begin
                        hold_left_next[i] = hold_left_reg[i] - 7'd1;
                        keys_out          = keys_out | held_key_reg[i];
                    end
                end

                skip_out = (skip_cnt_next != 7'd0);
                if (!skip_out && refresh_reg != 10'd0) begin
                    if ((cur.now_ms - last_drawn_reg) < 32'(refresh_reg)) begin
                        skip_out = 1'b1;
                    end else begin
                        last_drawn_next = cur.now_ms;
                    end
                end
            end
            default: ;  // unused command: no state change, no beat
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg    <= 32'd0;
            last_drawn_reg   <= 32'd0;
            vframes_reg      <= 32'd0;
            skip_cnt_reg     <= 7'd0;
            held_key_reg[0]  <= 32'd0;
            held_key_reg[1]  <= 32'd0;
            hold_left_reg[0] <= 7'd0;
            hold_left_reg[1] <= 7'd0;
        end else if (fire) begin
            last_time_reg  <= last_time_next;
            last_drawn_reg <= last_drawn_next;
            vframes_reg    <= vframes_next;
            skip_cnt_reg   <= skip_cnt_next;
            held_key_reg   <= held_key_next;
            hold_left_reg  <= hold_left_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        m_skip_reg;
    logic [31:0] m_keys_reg;
    logic [9:0]  m_wait_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld_out) begin
            m_valid_reg <= fire && tick_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            m_skip_reg <= skip_out;
            m_keys_reg <= keys_out;
            m_wait_reg <= wait_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_skip_reg;
    assign m_tdata  = {6'd0, m_wait_reg, m_keys_reg};

endmodule

### dv/frame_skip_pacer_tb.sv
`timescale 1ns / 100ps

module frame_skip_pacer_tb;

    // cmd 3 has no name in the package; the block must drop it
    localparam fsp_pkg::cmd_t CMD_UNUSED = fsp_pkg::cmd_t'(2'b11);
    // margin after the last result so the pipe is empty before touching registers
    localparam int   DRAIN_CYCLES = 16;
    // hang guard limit in ns, at a 2 ns clock period
    localparam int   TIMEOUT_NS   = 2_000_000;

    // one expected result beat
    typedef struct {
        logic        skip_render;
        logic [31:0] merged_keys;
        logic [9:0]  wait_ms;
    } frame_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // now_ms, key_states, ball_key_a, ball_time_a, ball_key_b, ball_time_b (low bit up)
    logic [143:0]        s_tdata  = '0;
    // cmd
    logic [1:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // merged_keys, wait_ms, zero pad (low bit up)
    logic [47:0]         m_tdata;
    // skip_render
    logic                m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [fsp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor copy of the registers
    logic [7:0]  cfg_fps      = fsp_pkg::FPS_RESET;
    logic [9:0]  cfg_interval = fsp_pkg::INTERVAL_RESET;
    logic [6:0]  cfg_max_skip = fsp_pkg::MAX_SKIP_RESET;
    logic        cfg_auto     = fsp_pkg::AUTO_RESET;
    logic [9:0]  cfg_refresh  = fsp_pkg::REFRESH_RESET;

    // predictor copy of the pacing state
    logic [31:0] start_ms     = '0;
    logic [31:0] last_ms      = '0;
    logic [31:0] last_drawn   = '0;
    logic [31:0] vframes      = '0;
    logic [6:0]  skip_cnt     = '0;
    logic [31:0] held_key [2] = '{default: '0};
    logic [6:0]  hold_left[2] = '{default: '0};

    frame_result_t pending_frames[$];
    int            err_cnt     = 0;
    int            items_sent  = 0;
    bit            tx_idle_en  = 1'b1;
    bit            rx_stall_en = 1'b1;
    int            stall_left  = 0;

    frame_skip_pacer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // trackball slot: new nonzero key restarts the hold, zero key is no event
    function automatic void load_held_key(int slot, logic [31:0] key, logic [7:0] add);
        logic [8:0] sum;
        if (key == '0) return;
        if (held_key[slot] != key) begin
            hold_left[slot] = '0;
            held_key[slot]  = key;
        end
        sum = {2'b00, hold_left[slot]} + {1'b0, add};
        hold_left[slot] = (sum > 9'(fsp_pkg::HOLD_LIMIT)) ? fsp_pkg::HOLD_LIMIT : sum[6:0];
    endfunction

    function automatic void predict_pacing(fsp_pkg::item_t it);
        logic [63:0]   prod;
        logic [31:0]   elapsed;
        logic [31:0]   due;
        logic [31:0]   delta;
        logic [31:0]   keys;
        logic [7:0]    cnt;
        logic [9:0]    wait_v;
        logic          skip;
        frame_result_t r;

        if (it.cmd == fsp_pkg::CMD_START) begin
            start_ms   = it.now_ms;
            last_ms    = it.now_ms;
            last_drawn = '0;
            vframes    = '0;
            skip_cnt   = '0;
            return;
        end
        if (it.cmd == fsp_pkg::CMD_BALL) begin
            load_held_key(0, it.ball_key_a, it.ball_time_a);
            load_held_key(1, it.ball_key_b, it.ball_time_b);
            return;
        end
        if (it.cmd != fsp_pkg::CMD_TICK) return;

        // frames that real time allows; product kept 64 bits wide
        elapsed = it.now_ms - start_ms;
        prod    = 64'(elapsed) * 64'(cfg_fps);
        due     = 32'(prod / 64'(fsp_pkg::MS_PER_SEC));
        vframes = vframes + 32'd1;
        cnt     = {1'b0, skip_cnt};
        wait_v  = '0;
        if (due >= vframes) begin
            // behind: catch up by skipping, or give up and resync
            if (due > vframes && cfg_auto && cnt < {1'b0, cfg_max_skip}) begin
                cnt = cnt + 8'd1;
            end else begin
                vframes = due;
                if (cfg_auto) cnt = '0;
            end
        end else begin
            // ahead: wait out the rest of the frame interval
            delta = it.now_ms - last_ms;
            if (delta < 32'(cfg_interval)) wait_v = cfg_interval - delta[9:0];
        end
        if (!cfg_auto) begin
            cnt = cnt + 8'd1;
            if (cnt > {1'b0, cfg_max_skip}) cnt = '0;
        end
        skip_cnt = cnt[6:0];
        last_ms  = it.now_ms;

        keys = it.key_states;
        for (int i = 0; i < 2; i++) begin
            if (hold_left[i] != '0) begin
                hold_left[i] = hold_left[i] - 7'd1;
                keys = keys | held_key[i];
            end
        end

        // refresh gating only applies to frames that would be drawn
        skip = (skip_cnt != '0);
        if (!skip && cfg_refresh != '0) begin
            if ((it.now_ms - last_drawn) < 32'(cfg_refresh)) skip = 1'b1;
            else last_drawn = it.now_ms;
        end

        r.skip_render = skip;
        r.merged_keys = keys;
        r.wait_ms     = wait_v;
        pending_frames.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------

    // idle length for stalls and gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_en && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every accepted result beat is matched against the oldest prediction
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected result beat: skip_render %0b merged_keys %h wait_ms %0d",
                       m_tuser, m_tdata[31:0], m_tdata[41:32]);
                err_cnt++;
            end else begin
                want = pending_frames.pop_front();
                if (m_tuser !== want.skip_render) begin
                    $error("skip_render: expected %0b, actual %0b", want.skip_render, m_tuser);
                    err_cnt++;
                end
                if (m_tdata[31:0] !== want.merged_keys) begin
                    $error("merged_keys: expected %h, actual %h",
                           want.merged_keys, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[41:32] !== want.wait_ms) begin
                    $error("wait_ms: expected %0d, actual %0d", want.wait_ms, m_tdata[41:32]);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // unused fields get random content so every bit toggles
    function automatic fsp_pkg::item_t make_item(fsp_pkg::cmd_t c, logic [31:0] now,
                                                 logic [31:0] keys);
        fsp_pkg::item_t it;
        it.cmd         = c;
        it.now_ms      = now;
        it.key_states  = keys;
        it.ball_key_a  = $urandom;
        it.ball_time_a = 8'($urandom_range(0, 255));
        it.ball_key_b  = $urandom;
        it.ball_time_b = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // drive one beat, predict on acceptance, then maybe idle;
    // valid stays high when the next beat follows at once
    task automatic send_beat(fsp_pkg::item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.ball_time_b, it.ball_key_b, it.ball_time_a, it.ball_key_a,
                     it.key_states, it.now_ms};
        do @(posedge aclk); while (!s_tready);
        predict_pacing(it);
        items_sent++;
        gap = (tx_idle_en && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_tick(logic [31:0] now, logic [31:0] keys);
        send_beat(make_item(fsp_pkg::CMD_TICK, now, keys));
    endtask

    task automatic send_start(logic [31:0] now);
        send_beat(make_item(fsp_pkg::CMD_START, now, $urandom));
    endtask

    task automatic send_ball(logic [31:0] key_a, logic [7:0] t_a,
                             logic [31:0] key_b, logic [7:0] t_b);
        fsp_pkg::item_t it;
        it = make_item(fsp_pkg::CMD_BALL, $urandom, $urandom);
        it.ball_key_a  = key_a;
        it.ball_time_a = t_a;
        it.ball_key_b  = key_b;
        it.ball_time_b = t_b;
        send_beat(it);
    endtask

    // no more beats until every result is out and the pipe is empty
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // setup then access phase; register lands on the access edge
    task automatic apb_write(fsp_pkg::reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fsp_pkg::REG_FPS:      cfg_fps      = val[7:0];
            fsp_pkg::REG_INTERVAL: cfg_interval = val[9:0];
            fsp_pkg::REG_MAX_SKIP: cfg_max_skip = val[6:0];
            fsp_pkg::REG_AUTO:     cfg_auto     = val[0];
            fsp_pkg::REG_REFRESH:  cfg_refresh  = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_pacing(int fps, int interval, int max_skip, int auto_on, int refresh);
        drain_pipeline();
        apb_write(fsp_pkg::REG_FPS,      32'(fps));
        apb_write(fsp_pkg::REG_INTERVAL, 32'(interval));
        apb_write(fsp_pkg::REG_MAX_SKIP, 32'(max_skip));
        apb_write(fsp_pkg::REG_AUTO,     32'(auto_on));
        apb_write(fsp_pkg::REG_REFRESH,  32'(refresh));
    endtask

    // start, then mostly paced ticks with jitter, lag bursts and trackball
    // events; a little noise (unused cmd, stray start, wild timestamps)
    task automatic run_session(int n, bit pause_mid);
        logic [31:0] now;
        logic [31:0] pool[4];
        logic [31:0] keys;
        int          pick;
        int          step;

        pool[0] = 32'd1 << $urandom_range(0, 31);
        pool[1] = 32'd1 << $urandom_range(0, 31);
        pool[2] = $urandom;
        pool[3] = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 3)      now = $urandom;
        else if (pick < 5) now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        else               now = $urandom_range(0, 100000);
        send_start(now);

        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) begin
                s_tvalid <= 1'b0;
                while (pending_frames.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_ball(($urandom_range(0, 4) == 0) ? 32'd0 : pool[2'($urandom_range(0, 3))],
                          8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 12)),
                          ($urandom_range(0, 4) == 0) ? 32'd0 : pool[2'($urandom_range(0, 3))],
                          8'($urandom_range(0, 255)));
            end else if (pick < 12) begin
                send_beat(make_item(CMD_UNUSED, $urandom, $urandom));
            end else if (pick < 13) begin
                send_start(now);
            end else if (pick < 14) begin
                send_tick($urandom, $urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    step = int'(cfg_interval) + int'($urandom_range(0, 4)) - 2;
                    if (step < 0) step = 0;
                end else if (pick < 75) begin
                    step = $urandom_range(0, int'(cfg_interval) - 1);
                end else if (pick < 90) begin
                    step = int'(cfg_interval) * int'($urandom_range(2, 12));
                end else begin
                    step = $urandom_range(0, 5000);
                end
                now  = now + 32'(step);
                pick = $urandom_range(0, 9);
                if (pick < 5)      keys = $urandom;
                else if (pick < 8) keys = '0;
                else               keys = 32'd1 << $urandom_range(0, 31);
                send_tick(now, keys);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset settings: 60 fps, 16 ms, 2 skips, auto, no refresh gating
    task automatic test_directed_pacing();
        send_tick(32'd100, 32'h0000_0000);          // before any start, behind
        send_beat(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_start(32'd1000);
        send_tick(32'd1005, 32'hFFFF_FFFF);         // ahead, waits 11
        send_tick(32'd1005, 32'h0000_0000);         // ahead, waits full interval
        send_tick(32'd1100, 32'h8000_0001);         // behind, skip 1
        send_tick(32'd1101, 32'h5555_5555);         // skip 2
        send_tick(32'd1102, 32'hAAAA_AAAA);         // limit hit, resync
        send_tick(32'd101000, 32'h0000_0000);       // long stall
        send_start(32'hFFFF_FFF0);
        send_tick(32'h0000_0010, 32'h0000_0001);    // elapsed wraps
        send_tick(32'hFFFF_FFFF, 32'h0000_0000);    // huge delta, no wait
        send_start(32'd0);
        send_tick(32'd0, 32'hFFFF_FFFF);
        send_start(32'd1);
        send_tick(32'd0, 32'h0000_0000);            // widest elapsed
        send_tick(32'd0, 32'h1234_5678);
    endtask

    task automatic test_trackball_hold();
        send_start(32'd5000);
        send_ball(32'h0000_0001, 8'd255, 32'h8000_0000, 8'd3);  // saturate / short hold
        send_ball(32'h0000_0000, 8'd7, 32'h0000_0000, 8'd9);    // zero keys: no change
        repeat (4) send_tick(32'd5000, 32'h0000_0000);
        send_ball(32'h0000_0001, 8'd10, 32'h8000_0000, 8'd2);   // same key adds up
        send_ball(32'hFFFF_FFFF, 8'd5, 32'h0000_00F0, 8'd0);    // new key restarts hold
        repeat (6) send_tick(32'd5016, 32'h0000_0100);
        send_start(32'd6000);                                   // held keys survive
        send_tick(32'd6000, 32'h0000_0000);
    endtask

    task automatic test_config_extremes();
        set_pacing(240, 1, 0, 1, 1000);
        run_session(30, 1'b0);
        set_pacing(0, 1000, 99, 0, 0);          // zero rate: never behind
        run_session(30, 1'b0);
        set_pacing(1, 1000, 99, 1, 1);
        run_session(30, 1'b0);
        set_pacing(240, 4, 99, 0, 1000);
        run_session(30, 1'b0);
    endtask

    // lowering max_skips under a live skip count
    task automatic test_skip_limit_lowered();
        set_pacing(60, 16, 99, 1, 0);
        send_start(32'd5000);
        repeat (6) send_tick(32'd15000, $urandom);  // auto: count climbs to 6
        drain_pipeline();
        apb_write(fsp_pkg::REG_MAX_SKIP, 32'd2);
        repeat (3) send_tick(32'd15001, $urandom);  // cleared on first tick
        set_pacing(60, 16, 50, 0, 0);
        send_start(32'd0);
        for (int i = 1; i <= 10; i++) send_tick(32'(16 * i), $urandom);
        drain_pipeline();
        apb_write(fsp_pkg::REG_MAX_SKIP, 32'd3);
        repeat (5) send_tick(32'd200, $urandom);    // fixed: wraps past new limit
    endtask

    task automatic test_random_sessions();
        int goal;
        int fps;
        int interval;
        int pick;
        bit paused;
        goal   = items_sent + 500;
        paused = 1'b0;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)     fps = 0;
            else if (pick < 3) fps = 240;
            else if (pick < 5) fps = 1;
            else               fps = $urandom_range(1, 240);
            pick = $urandom_range(0, 9);
            if (pick == 0)              interval = 1;
            else if (pick == 1)         interval = 1000;
            else if (pick < 6 && fps > 0) interval = 1000 / fps;
            else                        interval = $urandom_range(1, 1000);
            if (interval == 0) interval = 1;
            pick = $urandom_range(0, 9);
            set_pacing(fps, interval,
                       pick < 2 ? 0 : (pick == 2 ? 99 : $urandom_range(0, 10)),
                       $urandom_range(0, 1),
                       pick < 4 ? 0 : (pick == 4 ? 1000 : $urandom_range(1, 2 * interval)));
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            run_session($urandom_range(40, 110), !paused);
            paused = 1'b1;
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_pacing();
        test_trackball_hold();
        test_config_extremes();
        test_skip_limit_lowered();
        test_random_sessions();

        drain_pipeline();
        if (err_cnt == 0 && pending_frames.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
